### rtl/rbcr_pkg.sv
package rbcr_pkg;

  localparam int HANDLE_W = 12;
  localparam int COUNT_W  = 8;
  localparam int FREE_W   = 9;

  localparam int QDEPTH = 8;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [FREE_W-1:0] POOL_SIZE   = FREE_W'(8);
  localparam logic [QCNT_W-1:0] QDEPTH_C    = QCNT_W'(QDEPTH);
  localparam logic [QCNT_W-1:0] QFULL_C     = QCNT_W'(QDEPTH - 1);
  localparam logic [COUNT_W-1:0] THR_RESET  = COUNT_W'(4);

  localparam logic [1:0] OP_TAKE      = 2'd0;
  localparam logic [1:0] OP_REFILL_OK = 2'd1;
  localparam logic [1:0] OP_REFILL_NG = 2'd2;
  localparam logic [1:0] OP_INVAL     = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_REFILL_NG  = 2'd2;
  localparam logic [1:0] ST_NO_REFILL  = 2'd3;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] conn_handle;
  } in_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                send_credit;
    logic [HANDLE_W-1:0] credit_handle;
    logic [COUNT_W-1:0]  credit_count;
  } out_res_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
  } qent_t;

  typedef enum logic [2:0] {
    Q_NONE,
    Q_POP,
    Q_PUSH,
    Q_WRITE,
    Q_INVAL
  } qop_t;

  typedef struct packed {
    qop_t  op;
    qent_t entry;
  } qcmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP1,
    S_STEP2
  } seq_state_t;

endpackage

### rtl/rbcr_cell.sv
module rbcr_cell (
  input  logic          clk,
  input  rbcr_pkg::qcmd_t cmd,
  input  logic          active,
  input  logic          tail,
  input  rbcr_pkg::qent_t prev_ent,
  input  rbcr_pkg::qent_t next_ent,
  output rbcr_pkg::qent_t ent
);

  rbcr_pkg::qent_t ent_r;
  rbcr_pkg::qent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      rbcr_pkg::Q_NONE: begin
        ent_nxt = ent_r;
      end
      rbcr_pkg::Q_POP: begin
        ent_nxt = next_ent;
      end
      rbcr_pkg::Q_PUSH: begin
        ent_nxt = prev_ent;
      end
      rbcr_pkg::Q_WRITE: begin
        if (tail) begin
          ent_nxt = cmd.entry;
        end
      end
      rbcr_pkg::Q_INVAL: begin
        if (active && ent_r.valid && (ent_r.handle == cmd.entry.handle)) begin
          ent_nxt.valid = 1'b0;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

### rtl/rbcr_queue.sv
module rbcr_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbcr_pkg::qcmd_t               cmd,
  output rbcr_pkg::qent_t               head,
  output logic [rbcr_pkg::QCNT_W-1:0]   count
);

  logic [rbcr_pkg::QCNT_W-1:0] count_r;
  logic [rbcr_pkg::QCNT_W-1:0] count_nxt;

  rbcr_pkg::qent_t ents   [rbcr_pkg::QDEPTH];
  rbcr_pkg::qent_t prevs  [rbcr_pkg::QDEPTH];
  rbcr_pkg::qent_t nexts  [rbcr_pkg::QDEPTH];

  for (genvar i = 0; i < rbcr_pkg::QDEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prevs[i] = cmd.entry;
    end else begin : g_prev
      assign prevs[i] = ents[i-1];
    end
    if (i == rbcr_pkg::QDEPTH - 1) begin : g_last
      assign nexts[i] = ents[i];
    end else begin : g_next
      assign nexts[i] = ents[i+1];
    end

    rbcr_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .active   (rbcr_pkg::QCNT_W'(i) < count_r),
      .tail     (rbcr_pkg::QCNT_W'(i) == count_r),
      .prev_ent (prevs[i]),
      .next_ent (nexts[i]),
      .ent      (ents[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    unique case (cmd.op)
      rbcr_pkg::Q_POP: begin
        count_nxt = count_r - rbcr_pkg::QCNT_W'(1);
      end
      rbcr_pkg::Q_PUSH: begin
        if (count_r < rbcr_pkg::QDEPTH_C) begin
          count_nxt = count_r + rbcr_pkg::QCNT_W'(1);
        end
      end
      rbcr_pkg::Q_WRITE: begin
        count_nxt = count_r + rbcr_pkg::QCNT_W'(1);
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = ents[0];
  assign count = count_r;

endmodule

### rtl/rx_buffer_credit_return_top.sv
// Channel | Ports                              | Transfer
// input   | in_valid, in_stall, in_req         | in_valid & !in_stall
// result  | out_valid, out_stall, out_res      | out_valid & !out_stall
// config  | cfg_valid, cfg_ready, cfg_data     | cfg_valid & cfg_ready
//
// Each request: step one may start a queued refill or runs the opcode,
// step two runs the take or the follow-up refill start; one queue shift per cycle.
// One result per request, held in an output register; the next request is taken
// in the cycle the previous one writes its result.
// Synchronous active-low reset: 8 free buffers, empty queue, threshold 4.
// out_stall holds the result register, and in step two the sequencer and the input.
module rx_buffer_credit_return_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbcr_pkg::in_req_t             in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbcr_pkg::out_res_t            out_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbcr_pkg::COUNT_W-1:0]  cfg_data
);

  rbcr_pkg::seq_state_t state_r, state_nxt;
  logic [1:0]                     op_r, op_nxt;
  logic [rbcr_pkg::HANDLE_W-1:0]  hdl_r, hdl_nxt;
  logic [rbcr_pkg::COUNT_W-1:0]   thr_r;
  logic [rbcr_pkg::FREE_W-1:0]    free_r, free_nxt;
  logic                           busy_r, busy_nxt;
  rbcr_pkg::qent_t                infl_r, infl_nxt;
  rbcr_pkg::qent_t                bat_r, bat_nxt;
  logic [rbcr_pkg::COUNT_W-1:0]   bcnt_r, bcnt_nxt;
  rbcr_pkg::out_res_t             res_r, res_nxt;
  rbcr_pkg::out_res_t             out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  rbcr_pkg::qcmd_t                qcmd;
  rbcr_pkg::qent_t                q_head;
  logic [rbcr_pkg::QCNT_W-1:0]    q_count;

  logic                           out_free;
  logic                           in_take;

  rbcr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (qcmd),
    .head  (q_head),
    .count (q_count)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == rbcr_pkg::S_IDLE) ||
                       ((state_r == rbcr_pkg::S_STEP2) && out_free));
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    rbcr_pkg::qent_t              done;
    rbcr_pkg::qent_t              bh;
    logic                         other;
    logic                         ack;
    logic [rbcr_pkg::COUNT_W-1:0] cnt;

    state_nxt     = state_r;
    op_nxt        = op_r;
    hdl_nxt       = hdl_r;
    free_nxt      = free_r;
    busy_nxt      = busy_r;
    infl_nxt      = infl_r;
    bat_nxt       = bat_r;
    bcnt_nxt      = bcnt_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    qcmd.op       = rbcr_pkg::Q_NONE;
    qcmd.entry    = '0;
    done          = infl_r;
    bh            = bat_r;
    other         = 1'b0;
    ack           = 1'b0;
    cnt           = bcnt_r;

    unique case (state_r)
      rbcr_pkg::S_IDLE: begin
        if (in_take) begin
          op_nxt    = in_req.opcode;
          hdl_nxt   = in_req.conn_handle;
          state_nxt = rbcr_pkg::S_STEP1;
        end
      end

      rbcr_pkg::S_STEP1: begin
        res_nxt   = '0;
        state_nxt = rbcr_pkg::S_STEP2;
        unique case (op_r)
          rbcr_pkg::OP_TAKE: begin
            if ((q_count != '0) && !busy_r) begin
              infl_nxt = q_head;
              busy_nxt = 1'b1;
              qcmd.op  = rbcr_pkg::Q_POP;
            end
          end
          rbcr_pkg::OP_REFILL_OK: begin
            if (!busy_r) begin
              res_nxt.status = rbcr_pkg::ST_NO_REFILL;
            end else begin
              busy_nxt = 1'b0;
              infl_nxt = '0;
              if (free_r < rbcr_pkg::POOL_SIZE) begin
                free_nxt = free_r + rbcr_pkg::FREE_W'(1);
              end
              if (done.valid) begin
                bh    = bat_r.valid ? bat_r : done;
                other = (done != bh);
                if (other) begin
                  cnt = bcnt_r;
                  ack = 1'b1;
                end else begin
                  cnt = bcnt_r + rbcr_pkg::COUNT_W'(1);
                  ack = (cnt >= thr_r);
                end
                if (ack) begin
                  if (cnt != '0) begin
                    res_nxt.send_credit   = 1'b1;
                    res_nxt.credit_handle = bh.handle;
                    res_nxt.credit_count  = cnt;
                  end
                  bcnt_nxt = other ? rbcr_pkg::COUNT_W'(1) : '0;
                  bat_nxt  = done;
                end else begin
                  bcnt_nxt = cnt;
                  bat_nxt  = bh;
                end
              end
            end
          end
          rbcr_pkg::OP_REFILL_NG: begin
            if (!busy_r) begin
              res_nxt.status = rbcr_pkg::ST_NO_REFILL;
            end else begin
              qcmd.op        = rbcr_pkg::Q_PUSH;
              qcmd.entry     = infl_r;
              busy_nxt       = 1'b0;
              infl_nxt       = '0;
              res_nxt.status = rbcr_pkg::ST_REFILL_NG;
            end
          end
          rbcr_pkg::OP_INVAL: begin
            qcmd.op           = rbcr_pkg::Q_INVAL;
            qcmd.entry.handle = hdl_r;
            if (busy_r && infl_r.valid && (infl_r.handle == hdl_r)) begin
              infl_nxt.valid = 1'b0;
            end
            if (bat_r.valid && (bat_r.handle == hdl_r)) begin
              bat_nxt  = '0;
              bcnt_nxt = '0;
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      rbcr_pkg::S_STEP2: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          unique case (op_r)
            rbcr_pkg::OP_TAKE: begin
              if ((free_r == '0) || (busy_r && (q_count >= rbcr_pkg::QFULL_C))) begin
                out_nxt.status = rbcr_pkg::ST_OVERFLOW;
              end else begin
                free_nxt = free_r - rbcr_pkg::FREE_W'(1);
                if (busy_r) begin
                  qcmd.op           = rbcr_pkg::Q_WRITE;
                  qcmd.entry.valid  = 1'b1;
                  qcmd.entry.handle = hdl_r;
                end else begin
                  infl_nxt.valid  = 1'b1;
                  infl_nxt.handle = hdl_r;
                  busy_nxt        = 1'b1;
                end
              end
            end
            rbcr_pkg::OP_REFILL_OK: begin
              if ((res_r.status == rbcr_pkg::ST_OK) && (q_count != '0) && !busy_r) begin
                infl_nxt = q_head;
                busy_nxt = 1'b1;
                qcmd.op  = rbcr_pkg::Q_POP;
              end
            end
            default: begin
              qcmd.op = rbcr_pkg::Q_NONE;
            end
          endcase
          if (in_take) begin
            op_nxt    = in_req.opcode;
            hdl_nxt   = in_req.conn_handle;
            state_nxt = rbcr_pkg::S_STEP1;
          end else begin
            state_nxt = rbcr_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = rbcr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbcr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= rbcr_pkg::THR_RESET;
      free_r      <= rbcr_pkg::POOL_SIZE;
      busy_r      <= 1'b0;
      infl_r      <= '0;
      bat_r       <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      free_r      <= free_nxt;
      busy_r      <= busy_nxt;
      infl_r      <= infl_nxt;
      bat_r       <= bat_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    hdl_r <= hdl_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  a_qcount_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= rbcr_pkg::QDEPTH_C)
    else $error("refill queue count beyond depth");

  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= rbcr_pkg::POOL_SIZE)
    else $error("free count beyond pool size");

  a_idle_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (infl_r == '0))
    else $error("inflight handle set without a refill in flight");

  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    ((rbcr_pkg::FREE_W + 1)'(free_r) + (rbcr_pkg::FREE_W + 1)'(q_count) +
     (rbcr_pkg::FREE_W + 1)'(busy_r)) == (rbcr_pkg::FREE_W + 1)'(rbcr_pkg::POOL_SIZE))
    else $error("buffer accounting lost a buffer");

  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rbcr_pkg::S_STEP1) |=> (state_r == rbcr_pkg::S_STEP2))
    else $error("first step not followed by second step");

endmodule

### test/rx_buffer_credit_return_top_tb.sv
`timescale 1ns / 1ps

module rx_buffer_credit_return_top_tb;
  import rbcr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_req_t             in_req;
  logic                out_valid;
  logic                out_stall;
  out_res_t            out_res;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data;

  rx_buffer_credit_return_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // pool, refill queue and batch as the block should hold them
  int unsigned          pool_free;
  logic [HANDLE_W-1:0]  wait_handle [QDEPTH];
  logic                 wait_live [QDEPTH];
  int unsigned          wait_cnt;
  logic                 refill_busy;
  logic [HANDLE_W:0]    refill_tag;
  logic [HANDLE_W:0]    batch_tag;
  logic [COUNT_W-1:0]   batch_cnt;
  logic [COUNT_W-1:0]   ack_thr;

  out_res_t     expected_res [$];
  out_res_t     head_res;
  int unsigned  errors;
  int unsigned  sent_reqs;
  int unsigned  credits_seen;
  int unsigned  overflows_seen;
  int unsigned  idle_cycles;
  bit           calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void start_waiting_refill();
    if (wait_cnt == 0 || refill_busy) return;
    refill_tag  = {wait_live[0], wait_handle[0]};
    refill_busy = 1'b1;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      wait_handle[i] = wait_handle[i + 1];
      wait_live[i]   = wait_live[i + 1];
    end
    wait_cnt--;
  endfunction

  function automatic out_res_t credit_step(in_req_t r);
    out_res_t           res;
    logic [HANDLE_W:0]  done;
    logic               ack;
    logic               other;
    res = '0;
    case (r.opcode)
      OP_TAKE: begin
        start_waiting_refill();
        if (pool_free == 0 || (refill_busy && wait_cnt >= QDEPTH - 1)) begin
          res.status = ST_OVERFLOW;
        end else begin
          pool_free--;
          if (refill_busy) begin
            wait_handle[wait_cnt] = r.conn_handle;
            wait_live[wait_cnt]   = 1'b1;
            wait_cnt++;
          end else begin
            refill_tag  = {1'b1, r.conn_handle};
            refill_busy = 1'b1;
          end
        end
      end
      OP_REFILL_OK: begin
        if (!refill_busy) begin
          res.status = ST_NO_REFILL;
        end else begin
          done        = refill_tag;
          refill_busy = 1'b0;
          refill_tag  = '0;
          if (pool_free < POOL_SIZE) pool_free++;
          if (done[HANDLE_W]) begin
            if (!batch_tag[HANDLE_W]) batch_tag = done;
            other = (done != batch_tag);
            ack   = other;
            if (!ack) begin
              batch_cnt = batch_cnt + 1'b1;
              ack       = (batch_cnt >= ack_thr);
            end
            if (ack) begin
              if (batch_cnt > 0) begin
                res.send_credit   = 1'b1;
                res.credit_handle = batch_tag[HANDLE_W-1:0];
                res.credit_count  = batch_cnt;
              end
              batch_cnt = other ? COUNT_W'(1) : '0;
              batch_tag = done;
            end
          end
          start_waiting_refill();
        end
      end
      OP_REFILL_NG: begin
        if (!refill_busy) begin
          res.status = ST_NO_REFILL;
        end else begin
          for (int i = QDEPTH - 1; i > 0; i--) begin
            wait_handle[i] = wait_handle[i - 1];
            wait_live[i]   = wait_live[i - 1];
          end
          wait_handle[0] = refill_tag[HANDLE_W-1:0];
          wait_live[0]   = refill_tag[HANDLE_W];
          if (wait_cnt < QDEPTH) wait_cnt++;
          refill_busy = 1'b0;
          refill_tag  = '0;
          res.status  = ST_REFILL_NG;
        end
      end
      default: begin
        if (refill_busy && refill_tag == {1'b1, r.conn_handle})
          refill_tag = {1'b0, r.conn_handle};
        for (int i = 0; i < QDEPTH; i++) begin
          if (i < wait_cnt && wait_live[i] && wait_handle[i] == r.conn_handle)
            wait_live[i] = 1'b0;
        end
        if (batch_tag == {1'b1, r.conn_handle}) begin
          batch_tag = '0;
          batch_cnt = '0;
        end
      end
    endcase
    return res;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic in_req_t mk_req(logic [1:0] op, logic [HANDLE_W-1:0] h);
    in_req_t r;
    r.opcode      = op;
    r.conn_handle = h;
    return r;
  endfunction

  task automatic send_req(in_req_t r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    expected_res.push_back(credit_step(r));
    sent_reqs++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [COUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ack_thr = v;
  endtask

  task automatic random_traffic(int n, int take_w, int ok_w, int fail_w, int inval_w,
                                bit steady);
    logic [HANDLE_W-1:0] hset [3];
    in_req_t             r;
    int                  pick;
    int                  idx;
    int                  total;
    total = take_w + ok_w + fail_w + inval_w;
    foreach (hset[i]) hset[i] = HANDLE_W'($urandom_range(0, 4095));
    calm = steady;
    repeat (n) begin
      pick = $urandom_range(0, total - 1);
      if (pick < take_w) r.opcode = OP_TAKE;
      else if (pick < take_w + ok_w) r.opcode = OP_REFILL_OK;
      else if (pick < take_w + ok_w + fail_w) r.opcode = OP_REFILL_NG;
      else r.opcode = OP_INVAL;
      idx = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) r.conn_handle = HANDLE_W'($urandom_range(0, 4095));
      else r.conn_handle = hset[idx > 2 ? 0 : idx];
      send_req(r);
      if (!steady && $urandom_range(0, 39) == 0) calm = !calm;
    end
    calm = 1'b0;
  endtask

  task automatic test_edge_cases();
    in_req_t seq [$];
    seq = '{mk_req(OP_REFILL_OK, 12'h000), mk_req(OP_REFILL_NG, 12'hfff),
            mk_req(OP_INVAL, 12'hfff),
            mk_req(OP_TAKE, 12'h000), mk_req(OP_TAKE, 12'h000), mk_req(OP_TAKE, 12'h000),
            mk_req(OP_TAKE, 12'hfff), mk_req(OP_TAKE, 12'haaa), mk_req(OP_TAKE, 12'h555),
            mk_req(OP_TAKE, 12'h555), mk_req(OP_TAKE, 12'h123),
            mk_req(OP_TAKE, 12'hfff),
            mk_req(OP_REFILL_NG, 12'h000), mk_req(OP_INVAL, 12'haaa),
            mk_req(OP_TAKE, 12'h007),
            mk_req(OP_REFILL_OK, 12'h000), mk_req(OP_REFILL_OK, 12'h000),
            mk_req(OP_REFILL_OK, 12'h000), mk_req(OP_REFILL_OK, 12'h000),
            mk_req(OP_REFILL_OK, 12'h000), mk_req(OP_REFILL_OK, 12'h000),
            mk_req(OP_REFILL_OK, 12'h000), mk_req(OP_REFILL_OK, 12'h000),
            mk_req(OP_REFILL_OK, 12'h000)};
    foreach (seq[i]) send_req(seq[i]);
    drain();
  endtask

  task automatic test_mixed_traffic();
    random_traffic(250, 4, 4, 1, 1, 1'b0);
  endtask

  task automatic test_threshold_sweep();
    write_threshold(COUNT_W'(1));
    random_traffic(120, 4, 4, 1, 1, 1'b0);
    write_threshold('0);
    random_traffic(120, 4, 4, 1, 1, 1'b0);
    write_threshold(COUNT_W'($urandom_range(2, 254)));
    random_traffic(120, 4, 4, 1, 1, 1'b0);
  endtask

  task automatic test_long_batch();
    logic [HANDLE_W-1:0] h;
    h = HANDLE_W'($urandom_range(0, 4095));
    write_threshold(COUNT_W'(255));
    repeat (290) begin
      send_req(mk_req(OP_TAKE, h));
      if ($urandom_range(0, 7) == 0) send_req(mk_req(OP_REFILL_NG, h));
      send_req(mk_req(OP_REFILL_OK, h));
    end
  endtask

  task automatic test_invalidate_churn();
    write_threshold(COUNT_W'($urandom_range(1, 8)));
    random_traffic(150, 3, 3, 1, 3, 1'b0);
  endtask

  task automatic test_back_to_back();
    write_threshold(THR_RESET);
    random_traffic(120, 4, 4, 1, 1, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        $error("result %p arrived with no request outstanding", out_res);
        errors++;
      end else begin
        head_res = expected_res.pop_front();
        if (out_res.status !== head_res.status) begin
          $error("status: expected %0d, got %0d", head_res.status, out_res.status);
          errors++;
        end
        if (out_res.send_credit !== head_res.send_credit) begin
          $error("send_credit: expected %0d, got %0d",
                 head_res.send_credit, out_res.send_credit);
          errors++;
        end
        if (out_res.credit_handle !== head_res.credit_handle) begin
          $error("credit_handle: expected 0x%03h, got 0x%03h",
                 head_res.credit_handle, out_res.credit_handle);
          errors++;
        end
        if (out_res.credit_count !== head_res.credit_count) begin
          $error("credit_count: expected %0d, got %0d",
                 head_res.credit_count, out_res.credit_count);
          errors++;
        end
        if (out_res.send_credit === 1'b1) credits_seen++;
        if (out_res.status === ST_OVERFLOW) overflows_seen++;
      end
    end
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transfer for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    errors         = 0;
    sent_reqs      = 0;
    credits_seen   = 0;
    overflows_seen = 0;
    calm           = 1'b0;
    pool_free      = POOL_SIZE;
    wait_cnt       = 0;
    refill_busy    = 1'b0;
    refill_tag     = '0;
    batch_tag      = '0;
    batch_cnt      = '0;
    ack_thr        = THR_RESET;
    foreach (wait_handle[i]) begin
      wait_handle[i] = '0;
      wait_live[i]   = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_mixed_traffic();
    test_threshold_sweep();
    test_long_batch();
    test_invalidate_churn();
    test_back_to_back();
    drain();
    $display("Ran %0d requests: %0d credit messages and %0d overflow answers checked.",
             sent_reqs, credits_seen, overflows_seen);
    $display("Batch thresholds 0, 1, 4, 255 and random values, with and without stalls.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/rbcr_pkg.sv
rtl/rbcr_cell.sv
rtl/rbcr_queue.sv
rtl/rx_buffer_credit_return_top.sv
test/rx_buffer_credit_return_top_tb.sv
